>>> rtl/fcmst_pkg.sv
`timescale 1ns / 1ps

package fcmst_pkg;

    localparam int REQ_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int CNT_OUT_W = 5;

    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_COUNT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DUMP   = 3'd4;

    localparam logic [CNT_OUT_W-1:0] CNT_OUT_MAX = 5'd31;

    typedef logic [REQ_W-1:0] req_t;

endpackage

>>> rtl/fcmst_ram.sv
`timescale 1ns / 1ps

module fcmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/fixed_capacity_multiset_table.sv
`timescale 1ns / 1ps

// Bag of up to CAPACITY values held in a single-port-read RAM with an occupancy
// count. One request is taken at a time; in_ready is high only while the block
// is idle. Add, clear and unused request types need no RAM read. Count and
// remove walk the stored entries through the one read port and one comparator:
// count checks every entry, while remove stops at the first match, reads the
// last entry and writes it into the freed slot. Dump reads one entry at a time
// and emits one word per entry (a single word with item_valid low when
// empty). The result register lets the next request enter while a word waits.
module fixed_capacity_multiset_table
    import fcmst_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [VALUE_W-1:0]   item_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 success,
    output logic [CNT_OUT_W-1:0] match_count,
    output logic [CNT_OUT_W-1:0] current_size,
    output logic [VALUE_W-1:0]   item_out,
    output logic                 item_valid,
    output logic                 last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MOVE = 3'd2;
    localparam logic [2:0] ST_WB   = 3'd3;
    localparam logic [2:0] ST_DRD  = 3'd4;
    localparam logic [2:0] ST_DOUT = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    function automatic logic [CNT_OUT_W-1:0] sat_cnt(input logic [CW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'(CNT_OUT_MAX)) ? CNT_OUT_MAX : CNT_OUT_W'(v);
    endfunction

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         scan_idx_reg, scan_idx_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]         at_reg, at_next;
    logic [CW-1:0]         match_reg, match_next;
    logic                  succ_reg, succ_next;
    req_t                  req_reg, req_next;
    logic [ITEM_WIDTH-1:0] val_reg, val_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  success_reg, success_next;
    logic [CNT_OUT_W-1:0]  match_count_reg, match_count_next;
    logic [CNT_OUT_W-1:0]  size_reg, size_next;
    logic [VALUE_W-1:0]    item_out_reg, item_out_next;
    logic                  item_valid_reg, item_valid_next;
    logic                  last_reg, last_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [ITEM_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [ITEM_WIDTH-1:0] ram_rdata;

    logic                  out_free;
    logic                  issue;
    logic                  hit;
    logic                  room;
    logic [CW-1:0]         last_idx;

    fcmst_ram #(
        .WIDTH(ITEM_WIDTH),
        .DEPTH(CAPACITY)
    ) u_store (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign issue    = scan_idx_reg < count_reg;
    assign hit      = pend_reg && (ram_rdata == val_reg);
    assign room     = count_reg < CW'(CAPACITY);
    assign last_idx = count_reg - CW'(1);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        scan_idx_next    = scan_idx_reg;
        pend_next        = pend_reg;
        cmp_idx_next     = cmp_idx_reg;
        at_next          = at_reg;
        match_next       = match_reg;
        succ_next        = succ_reg;
        req_next         = req_reg;
        val_next         = val_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        success_next     = success_reg;
        match_count_next = match_count_reg;
        size_next        = size_reg;
        item_out_next    = item_out_reg;
        item_valid_next  = item_valid_reg;
        last_next        = last_reg;
        ram_we           = 1'b0;
        ram_waddr        = count_reg[AW-1:0];
        ram_wdata        = val_reg;
        ram_raddr        = scan_idx_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next      = req_type;
                    val_next      = ITEM_WIDTH'(item_value);
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    match_next    = '0;
                    succ_next     = 1'b0;
                    state_next    = ST_EMIT;
                    unique case (req_type)
                        REQ_ADD:
                        begin
                            if (room)
                            begin
                                ram_we     = 1'b1;
                                ram_wdata  = ITEM_WIDTH'(item_value);
                                count_next = count_reg + CW'(1);
                                succ_next  = 1'b1;
                            end
                        end
                        REQ_REMOVE, REQ_COUNT:
                        begin
                            state_next = ST_SCAN;
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        REQ_DUMP:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_DRD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                pend_next    = issue;
                cmp_idx_next = scan_idx_reg[AW-1:0];
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (hit)
                begin
                    match_next = match_reg + CW'(1);
                end
                priority if (hit && req_reg == REQ_REMOVE)
                begin
                    at_next    = cmp_idx_reg;
                    state_next = ST_MOVE;
                end
                else if (!issue)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_MOVE:
            begin
                ram_raddr  = last_idx[AW-1:0];
                state_next = ST_WB;
            end
            ST_WB:
            begin
                ram_we     = 1'b1;
                ram_waddr  = at_reg;
                ram_wdata  = ram_rdata;
                count_next = last_idx;
                succ_next  = 1'b1;
                match_next = '0;
                state_next = ST_EMIT;
            end
            ST_DRD:
            begin
                state_next = ST_DOUT;
            end
            ST_DOUT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    success_next     = 1'b0;
                    match_count_next = '0;
                    size_next        = sat_cnt(count_reg);
                    item_out_next    = VALUE_W'(ram_rdata);
                    item_valid_next  = 1'b1;
                    last_next        = (scan_idx_reg == last_idx);
                    scan_idx_next    = scan_idx_reg + CW'(1);
                    state_next       = (scan_idx_reg == last_idx) ? ST_IDLE : ST_DRD;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    success_next     = succ_reg;
                    match_count_next = (req_reg == REQ_COUNT) ? sat_cnt(match_reg) : '0;
                    size_next        = sat_cnt(count_reg);
                    item_out_next    = '0;
                    item_valid_next  = 1'b0;
                    last_next        = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg     <= cmp_idx_next;
        at_reg          <= at_next;
        match_reg       <= match_next;
        succ_reg        <= succ_next;
        req_reg         <= req_next;
        val_reg         <= val_next;
        success_reg     <= success_next;
        match_count_reg <= match_count_next;
        size_reg        <= size_next;
        item_out_reg    <= item_out_next;
        item_valid_reg  <= item_valid_next;
        last_reg        <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign success      = success_reg;
    assign match_count  = match_count_reg;
    assign current_size = size_reg;
    assign item_out     = item_out_reg;
    assign item_valid   = item_valid_reg;
    assign last         = last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && req_type == REQ_ADD && room)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("accepted add with room did not grow the bag");

    a_wb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) |-> (CW'(at_reg) < count_reg))
        else $error("remove write-back outside occupied entries");

    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (match_reg <= count_reg))
        else $error("match count above occupancy");
`endif

endmodule

>>> tb/fixed_capacity_multiset_table_tb.sv
`timescale 1ns / 1ps

module fixed_capacity_multiset_table_tb;
    import fcmst_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int MAX_GAP      = 18;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 360;
    localparam int PHASES       = 4;
    localparam int PRINT_LIMIT  = 60;

    localparam req_t REQ_UNUSED_LO = 3'd5;
    localparam req_t REQ_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic                 success;
        logic [CNT_OUT_W-1:0] match_count;
        logic [CNT_OUT_W-1:0] current_size;
        logic [VALUE_W-1:0]   item_out;
        logic                 item_valid;
        logic                 last;
    } result_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    req_t                 req_type;
    logic [VALUE_W-1:0]   item_value;
    logic                 out_valid;
    logic                 out_ready;
    logic                 success;
    logic [CNT_OUT_W-1:0] match_count;
    logic [CNT_OUT_W-1:0] current_size;
    logic [VALUE_W-1:0]   item_out;
    logic                 item_valid;
    logic                 last;

    logic [VALUE_W-1:0] bag_store [CAPACITY];
    int                 bag_size = 0;
    result_word_t       pending_results [$];
    logic [VALUE_W-1:0] value_pool [8];
    int                 error_count = 0;
    int                 hold_cycles = 0;
    bit                 no_idle = 1'b0;

    fixed_capacity_multiset_table #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (VALUE_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .item_value   (item_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .success      (success),
        .match_count  (match_count),
        .current_size (current_size),
        .item_out     (item_out),
        .item_valid   (item_valid),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        if (error_count < PRINT_LIMIT)
        begin
            $display("mismatch %s at %0t: got %0h want %0h", what, $realtime, got, want);
        end
        error_count++;
    endtask

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    task automatic queue_result(input result_word_t word);
        pending_results = {pending_results, word};
    endtask

    task automatic predict_request(input req_t req, input logic [VALUE_W-1:0] value);
        result_word_t word;
        int           hit;
        int           equal_cnt;
        word = '0;
        word.last = 1'b1;
        case (req)
            REQ_ADD:
            begin
                if (bag_size < CAPACITY)
                begin
                    bag_store[bag_size] = value;
                    bag_size++;
                    word.success = 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                hit = -1;
                for (int i = 0; i < bag_size; i++)
                begin
                    if (hit < 0 && bag_store[i] == value)
                    begin
                        hit = i;
                    end
                end
                if (hit >= 0)
                begin
                    bag_size--;
                    bag_store[hit] = bag_store[bag_size];
                    word.success = 1'b1;
                end
            end
            REQ_COUNT:
            begin
                equal_cnt = 0;
                for (int i = 0; i < bag_size; i++)
                begin
                    if (bag_store[i] == value)
                    begin
                        equal_cnt++;
                    end
                end
                word.match_count = CNT_OUT_W'(equal_cnt);
            end
            REQ_CLEAR:
            begin
                bag_size = 0;
            end
            default:
            begin
            end
        endcase
        word.current_size = CNT_OUT_W'(bag_size);
        if (req == REQ_DUMP && bag_size > 0)
        begin
            for (int i = 0; i < bag_size; i++)
            begin
                word.item_out   = bag_store[i];
                word.item_valid = 1'b1;
                word.last       = (i == bag_size - 1);
                queue_result(word);
            end
        end
        else
        begin
            queue_result(word);
        end
    endtask

    task automatic send_request(input req_t req, input logic [VALUE_W-1:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        item_value <= value;
        do @(posedge clk); while (!in_ready);
        predict_request(req, value);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic req_t pick_request(input int add_weight);
        int r;
        int share;
        r = $urandom_range(0, 99);
        if (r < add_weight)
        begin
            return REQ_ADD;
        end
        share = (r - add_weight) * 100 / (100 - add_weight);
        if (share < 40)
        begin
            return REQ_REMOVE;
        end
        if (share < 70)
        begin
            return REQ_COUNT;
        end
        if (share < 82)
        begin
            return REQ_DUMP;
        end
        if (share < 88)
        begin
            return REQ_CLEAR;
        end
        return req_t'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r >= 5 && r <= 6 && bag_size > 0)
        begin
            return bag_store[$urandom_range(0, bag_size - 1)];
        end
        if (r <= 6)
        begin
            return value_pool[$urandom_range(0, 7)];
        end
        return $urandom();
    endfunction

    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected word", item_out, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (success !== want.success)
                    report_mismatch("success", VALUE_W'(success),
                                    VALUE_W'(want.success));
                if (match_count !== want.match_count)
                    report_mismatch("match_count", VALUE_W'(match_count),
                                    VALUE_W'(want.match_count));
                if (current_size !== want.current_size)
                    report_mismatch("current_size", VALUE_W'(current_size),
                                    VALUE_W'(want.current_size));
                if (item_out !== want.item_out)
                    report_mismatch("item_out", item_out, want.item_out);
                if (item_valid !== want.item_valid)
                    report_mismatch("item_valid", VALUE_W'(item_valid),
                                    VALUE_W'(want.item_valid));
                if (last !== want.last)
                    report_mismatch("last", VALUE_W'(last), VALUE_W'(want.last));
            end
        end
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                stall = draw_gap();
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic test_empty_bag();
        send_request(REQ_DUMP, '0);
        send_request(REQ_REMOVE, '0);
        send_request(REQ_COUNT, '1);
        send_request(REQ_UNUSED_HI, '1);
    endtask

    task automatic test_fill_to_capacity();
        logic [VALUE_W-1:0] value;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
                value = '0;
            else if (i == 1)
                value = '1;
            else if (i <= 4)
                value = 32'hA5A5_5A5A;
            else
                value = $urandom();
            send_request(REQ_ADD, value);
        end
        send_request(REQ_ADD, 32'h0BAD_F00D);
        send_request(REQ_DUMP, '0);
    endtask

    task automatic test_remove_and_count();
        send_request(REQ_COUNT, 32'hA5A5_5A5A);
        send_request(REQ_REMOVE, 32'hA5A5_5A5A);
        send_request(REQ_REMOVE, 32'h1234_5678);
        send_request(REQ_REMOVE, bag_store[bag_size - 1]);
        send_request(REQ_DUMP, '0);
        send_request(REQ_CLEAR, '1);
    endtask

    task automatic test_random_mix();
        int add_weight [PHASES] = '{60, 30, 45, 20};
        for (int p = 0; p < PHASES; p++)
        begin
            no_idle = (p == 2);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                send_request(pick_request(add_weight[p]), pick_value());
            end
            if (p == 1)
            begin
                wait_for_drain();
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_backpressure();
        wait_for_drain();
        hold_cycles = LONG_HOLD;
        no_idle = 1'b1;
        for (int n = 0; n < 24; n++)
        begin
            send_request(pick_request(50), pick_value());
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = REQ_ADD;
        item_value = '0;
        value_pool[0] = '0;
        value_pool[1] = '1;
        value_pool[2] = 32'h0000_0001;
        value_pool[3] = 32'h8000_0000;
        for (int i = 4; i < 8; i++)
        begin
            value_pool[i] = $urandom();
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_bag();
        test_fill_to_capacity();
        test_remove_and_count();
        test_random_mix();
        test_output_backpressure();
        wait_for_drain();
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
